// File: hw/rtl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

    localparam int DISC_W = 34;
    localparam int ROOT_W = 33;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_TWO     = 2'd1,
        KIND_DOUBLE  = 2'd2,
        KIND_COMPLEX = 2'd3
    } kind_t;

endpackage

// File: hw/rtl/qrs_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt_pipe #(
    parameter int NR   = 33,
    parameter int SB_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*NR-1:0]   in_rad,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [NR-1:0]     out_root,
    output logic [SB_W-1:0]   out_sb
);

    localparam int RAD_W = 2 * NR;
    localparam int REM_W = NR + 2;

    logic             v_reg    [NR];
    logic [REM_W-1:0] rem_reg  [NR];
    logic [NR-1:0]    root_reg [NR];
    logic [RAD_W-1:0] rad_reg  [NR];
    logic [SB_W-1:0]  sb_reg   [NR];

    for (genvar g = 0; g < NR; g++)
    begin : g_stage
        logic             v_prev;
        logic [REM_W-1:0] rem_prev;
        logic [NR-1:0]    root_prev;
        logic [RAD_W-1:0] rad_prev;
        logic [SB_W-1:0]  sb_prev;
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic             take;

        if (g == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = in_rad;
            assign sb_prev   = in_sb;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[g-1];
            assign rem_prev  = rem_reg[g-1];
            assign root_prev = root_reg[g-1];
            assign rad_prev  = rad_reg[g-1];
            assign sb_prev   = sb_reg[g-1];
        end

        assign rem_sh = {rem_prev, rad_prev[RAD_W-1 -: 2]};
        assign trial  = (REM_W + 2)'({root_prev, 2'b01});
        assign take   = (rem_sh >= trial);
        assign diff   = rem_sh - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg[g] <= {root_prev[NR-2:0], take};
                rad_reg[g]  <= {rad_prev[RAD_W-3:0], 2'b00};
                sb_reg[g]   <= sb_prev;
            end
        end
    end

    assign out_valid = v_reg[NR-1];
    assign out_root  = root_reg[NR-1];
    assign out_sb    = sb_reg[NR-1];

endmodule

// File: hw/rtl/qrs_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module qrs_div_pipe #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 17,
    parameter int SB_W  = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [SB_W-1:0]   out_sb
);

    logic             v_reg   [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [SB_W-1:0]  sb_reg  [NUM_W];

    for (genvar g = 0; g < NUM_W; g++)
    begin : g_stage
        logic             v_prev;
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] quo_prev;
        logic [NUM_W-1:0] num_prev;
        logic [DEN_W-1:0] den_prev;
        logic [SB_W-1:0]  sb_prev;
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W:0]   diff;
        logic             take;

        if (g == 0)
        begin : g_first
            assign v_prev   = in_valid;
            assign rem_prev = '0;
            assign quo_prev = '0;
            assign num_prev = in_num;
            assign den_prev = in_den;
            assign sb_prev  = in_sb;
        end
        else
        begin : g_rest
            assign v_prev   = v_reg[g-1];
            assign rem_prev = rem_reg[g-1];
            assign quo_prev = quo_reg[g-1];
            assign num_prev = num_reg[g-1];
            assign den_prev = den_reg[g-1];
            assign sb_prev  = sb_reg[g-1];
        end

        assign rem_sh = {rem_prev, num_prev[NUM_W-1]};
        assign take   = (rem_sh >= {1'b0, den_prev});
        assign diff   = rem_sh - {1'b0, den_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_reg[g] <= {quo_prev[NUM_W-2:0], take};
                num_reg[g] <= {num_prev[NUM_W-2:0], 1'b0};
                den_reg[g] <= den_prev;
                sb_reg[g]  <= sb_prev;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign out_quo   = quo_reg[NUM_W-1];
    assign out_sb    = sb_reg[NUM_W-1];

endmodule

// File: hw/rtl/quadratic_root_solver.sv
// Quadratic root solver top level: discriminant, square root and root division.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | coef_a, coef_b, coef_c
//   out     | output    | out_valid / out_stall| root_kind, disc_value, first_value,
//           |           |                      | second_value
//
// One item is accepted every cycle while in_stall is low.
// Latency is set by the square root pipe (one root bit per stage) and the
// divider pipes (one quotient bit per stage).
// The whole pipe advances together; an item at the output held by out_stall
// freezes every stage and raises in_stall. Reset clears only valid bits.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COEF_WIDTH-1:0] coef_a,
    input  logic signed [COEF_WIDTH-1:0] coef_b,
    input  logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   root_kind,
    output logic signed [DISC_W-1:0]     disc_value,
    output logic signed [ROOT_W-1:0]     first_value,
    output logic signed [ROOT_W-1:0]     second_value
);

    localparam int W       = COEF_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int DW      = 2 * W + 2;
    localparam int DEXT_W  = (DW > DISC_W) ? DW : DISC_W;
    localparam int MAG_W   = 2 * W + 1;
    localparam int NR      = W + F + 1;
    localparam int NB_W    = W + F + 1;
    localparam int NUM_W   = W + F + 2;
    localparam int DEN_W   = W + 1;
    localparam int EXT_W   = ((NUM_W + 1 > ROOT_W) ? NUM_W + 1 : ROOT_W) + 1;
    localparam int SQ_SB_W = 2 + DISC_W + NB_W + W;
    localparam int D1_SB_W = 1 + 2 + DISC_W;

    localparam logic signed [EXT_W-1:0] ROOT_MAX = EXT_W'((64'd1 << (ROOT_W - 1)) - 64'd1);
    localparam logic signed [EXT_W-1:0] ROOT_MIN = ~ROOT_MAX;

    logic adv;

    // stage 0: input capture
    logic                 v0_reg;
    logic signed [W-1:0]  a0_reg;
    logic signed [W-1:0]  b0_reg;
    logic signed [W-1:0]  c0_reg;

    // stage 1: products
    logic                   v1_reg;
    logic signed [2*W-1:0]  bb1_reg;
    logic signed [2*W-1:0]  ac1_reg;
    logic signed [W-1:0]    a1_reg;
    logic signed [W-1:0]    b1_reg;

    // stage 2: discriminant and classification
    logic                   v2_reg;
    kind_t                  kind2_reg;
    logic [DISC_W-1:0]      disc2_reg;
    logic [MAG_W-1:0]       mag2_reg;
    logic signed [NB_W-1:0] nb2_reg;
    logic signed [W-1:0]    a2_reg;
    logic signed [DW-1:0]   d_next;
    logic signed [DEXT_W-1:0] d_ext;
    logic [DW-1:0]          dmag_next;
    kind_t                  kind_next;

    // square root pipe
    logic               sq_valid;
    logic [NR-1:0]      sq_root;
    logic [SQ_SB_W-1:0] sq_sb;
    logic [1:0]         kind_s;
    logic [DISC_W-1:0]  disc_s;
    logic signed [NB_W-1:0] nb_s;
    logic signed [W-1:0]    a_s;

    // stage 3: numerators and divisor
    logic               v3_reg;
    logic [NUM_W-1:0]   num1_reg;
    logic [NUM_W-1:0]   num2_reg;
    logic [DEN_W-1:0]   den3_reg;
    logic [D1_SB_W-1:0] sb1_3_reg;
    logic               neg2_3_reg;
    logic signed [NUM_W:0] n1_next;
    logic signed [NUM_W:0] n2_next;
    logic signed [NUM_W:0] nb_ext;
    logic signed [NUM_W:0] s_ext;
    logic [NUM_W:0]        n1_abs;
    logic [NUM_W:0]        n2_abs;
    logic [W-1:0]          a_abs;

    // divider pipes
    logic               d1_valid;
    logic               d2_valid;
    logic [NUM_W-1:0]   q1;
    logic [NUM_W-1:0]   q2;
    logic [D1_SB_W-1:0] d1_sb;
    logic               d2_sb;
    kind_t              kind_q;

    // stage 4: output
    logic                     out_valid_reg;
    kind_t                    kind_reg;
    logic [DISC_W-1:0]        disc_reg;
    logic signed [ROOT_W-1:0] first_reg;
    logic signed [ROOT_W-1:0] second_reg;
    logic signed [ROOT_W-1:0] first_next;
    logic signed [ROOT_W-1:0] second_next;

    function automatic logic signed [ROOT_W-1:0] sat_root(
        input logic [NUM_W-1:0] q,
        input logic             neg
    );
        logic signed [EXT_W-1:0] v;
        logic signed [EXT_W-1:0] p;
        p = EXT_W'({1'b0, q});
        v = neg ? -p : p;
        if (v > ROOT_MAX)
        begin
            v = ROOT_MAX;
        end
        else if (v < ROOT_MIN)
        begin
            v = ROOT_MIN;
        end
        return v[ROOT_W-1:0];
    endfunction

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= sq_valid;
            out_valid_reg <= d1_valid;
        end
    end

    // stage 0 and 1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg  <= coef_a;
            b0_reg  <= coef_b;
            c0_reg  <= coef_c;
            bb1_reg <= b0_reg * b0_reg;
            ac1_reg <= a0_reg * c0_reg;
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
        end
    end

    // stage 2
    always_comb
    begin
        d_next    = DW'(bb1_reg) - (DW'(ac1_reg) <<< 2);
        d_ext     = DEXT_W'(d_next);
        dmag_next = d_next[DW-1] ? DW'(-d_next) : DW'(d_next);
        if (a1_reg == '0)
        begin
            kind_next = KIND_NONE;
        end
        else if (d_next[DW-1])
        begin
            kind_next = KIND_COMPLEX;
        end
        else if (d_next == '0)
        begin
            kind_next = KIND_DOUBLE;
        end
        else
        begin
            kind_next = KIND_TWO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind2_reg <= kind_next;
            disc2_reg <= (kind_next == KIND_NONE) ? '0 : d_ext[DISC_W-1:0];
            mag2_reg  <= dmag_next[MAG_W-1:0];
            nb2_reg   <= -(NB_W'(b1_reg) <<< F);
            a2_reg    <= a1_reg;
        end
    end

    qrs_sqrt_pipe #(
        .NR   (NR),
        .SB_W (SQ_SB_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v2_reg),
        .in_rad    ({1'b0, mag2_reg, (2 * F)'(0)}),
        .in_sb     ({kind2_reg, disc2_reg, nb2_reg, a2_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb)
    );

    // stage 3
    always_comb
    begin
        {kind_s, disc_s, nb_s, a_s} = sq_sb;
        nb_ext = (NUM_W + 1)'(nb_s);
        s_ext  = (NUM_W + 1)'({1'b0, sq_root});
        case (kind_s)
            KIND_TWO:
            begin
                n1_next = nb_ext + s_ext;
                n2_next = nb_ext - s_ext;
            end
            KIND_COMPLEX:
            begin
                n1_next = nb_ext;
                n2_next = s_ext;
            end
            default:
            begin
                n1_next = nb_ext;
                n2_next = nb_ext;
            end
        endcase
        n1_abs = n1_next[NUM_W] ? (NUM_W + 1)'(-n1_next) : (NUM_W + 1)'(n1_next);
        n2_abs = n2_next[NUM_W] ? (NUM_W + 1)'(-n2_next) : (NUM_W + 1)'(n2_next);
        a_abs  = a_s[W-1] ? W'(-a_s) : W'(a_s);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_reg   <= n1_abs[NUM_W-1:0];
            num2_reg   <= n2_abs[NUM_W-1:0];
            den3_reg   <= {a_abs, 1'b0};
            sb1_3_reg  <= {n1_next[NUM_W] ^ a_s[W-1], kind_s, disc_s};
            neg2_3_reg <= n2_next[NUM_W] ^ a_s[W-1];
        end
    end

    qrs_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .SB_W  (D1_SB_W)
    ) u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_num    (num1_reg),
        .in_den    (den3_reg),
        .in_sb     (sb1_3_reg),
        .out_valid (d1_valid),
        .out_quo   (q1),
        .out_sb    (d1_sb)
    );

    qrs_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .SB_W  (1)
    ) u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_num    (num2_reg),
        .in_den    (den3_reg),
        .in_sb     (neg2_3_reg),
        .out_valid (d2_valid),
        .out_quo   (q2),
        .out_sb    (d2_sb)
    );

    // stage 4
    always_comb
    begin
        kind_q = kind_t'(d1_sb[DISC_W+1:DISC_W]);
        if (kind_q == KIND_NONE)
        begin
            first_next  = '0;
            second_next = '0;
        end
        else
        begin
            first_next  = sat_root(q1, d1_sb[D1_SB_W-1]);
            second_next = sat_root(q2, d2_sb);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg   <= kind_q;
            disc_reg   <= d1_sb[DISC_W-1:0];
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign root_kind    = kind_reg;
    assign disc_value   = disc_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        d1_valid == d2_valid)
        else $error("divider pipes out of step");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_NONE |->
            disc_reg == '0 && first_reg == '0 && second_reg == '0)
        else $error("non-quadratic item carries nonzero fields");

    a_double_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_DOUBLE |->
            first_reg == second_reg && disc_reg == '0)
        else $error("double root fields differ");

    a_hold_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(v3_reg) && $stable(v0_reg))
        else $error("pipe advanced while output held");

endmodule
